// ===== src/tmwf_pkg.sv =====
package tmwf_pkg;

   // Window geometry
   localparam int WINDOW_MAX = 16;
   localparam int LEN_MIN    = 3;
   localparam int LEN_RESET  = 12;
   localparam int AXES       = 3;

   // Field widths
   localparam int SAMPLE_W  = 16;
   localparam int MEAN_W    = 24;
   localparam int LEN_W     = 5;
   localparam int FRAC_W    = 8;

   // Derived widths
   localparam int IDX_W     = $clog2(WINDOW_MAX);
   localparam int LEN_EFF_W = $clog2(WINDOW_MAX + 1);
   localparam int SUM_W     = SAMPLE_W + $clog2(WINDOW_MAX);
   localparam int MAG_W     = SUM_W - 1;
   localparam int DVD_W     = MAG_W + FRAC_W;
   localparam int DIV_W     = $clog2(WINDOW_MAX - 1);
   localparam int DCNT_W    = $clog2(DVD_W);
   localparam int ROW_W     = AXES * SAMPLE_W;

   typedef logic [ROW_W-1:0] row_type;

   // Controller states
   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_SCAN  = 6'b000010,
      S_DRAIN = 6'b000100,
      S_TRIM  = 6'b001000,
      S_DIV   = 6'b010000,
      S_OUT   = 6'b100000
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic write;
      logic rd_start;
      logic rd_en;
      logic div_load;
      logic div_step;
      logic out_load;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic filled_next;
      logic rd_last;
      logic div_last;
   } status_type;

endpackage

// ===== src/tmwf_ctrl.sv =====
module tmwf_ctrl
   import tmwf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      out_free;

   assign accept   = req_valid && (state_ff == S_IDLE);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Sequence one item: write it; once the window is full, scan it, drain, trim, divide, deliver
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.write    = 1'b1;
               cmd.rd_start = 1'b1;
               if (status.filled_next) begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            cmd.rd_en = 1'b1;
            if (status.rd_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_TRIM;
         end
         S_TRIM: begin
            cmd.div_load = 1'b1;
            state_in     = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Raise valid on load, drop it once the item is taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== src/tmwf_dp.sv =====
module tmwf_dp
   import tmwf_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_en,
   input  logic [LEN_W-1:0]           csr_write_data,
   input  logic signed [SAMPLE_W-1:0] sample_x,
   input  logic signed [SAMPLE_W-1:0] sample_y,
   input  logic signed [SAMPLE_W-1:0] sample_z,
   input  cmd_type                    cmd,
   output status_type                 status,
   output logic signed [MEAN_W-1:0]   mean_x,
   output logic signed [MEAN_W-1:0]   mean_y,
   output logic signed [MEAN_W-1:0]   mean_z
);

   logic [LEN_W-1:0]     window_len_ff;
   logic                 filled_ff;
   logic [IDX_W-1:0]     slot_ff;
   logic [LEN_EFF_W-1:0] len_eff;
   logic [IDX_W-1:0]     slot_use;
   logic [LEN_EFF_W-1:0] slot_next;
   logic                 wrap;
   logic [DIV_W-1:0]     divisor;

   row_type              store_ff [WINDOW_MAX];
   row_type              row;
   row_type              rd_data_ff;
   logic [IDX_W-1:0]     rd_idx_ff;
   logic                 rd_vld_ff;
   logic                 rd_first_ff;

   logic signed [SUM_W-1:0]    sum_ff [AXES];
   logic signed [SAMPLE_W-1:0] lo_ff  [AXES];
   logic signed [SAMPLE_W-1:0] hi_ff  [AXES];
   logic                       neg_ff [AXES];
   logic [DVD_W-1:0]           dvd_ff [AXES];
   logic [DIV_W-1:0]           rem_ff [AXES];
   logic [MEAN_W-1:0]          mean_ff [AXES];
   logic [DCNT_W-1:0]          div_cnt_ff;

   logic signed [SUM_W:0] trim   [AXES];
   logic [SUM_W:0]        trim_a [AXES];
   logic [DIV_W:0]        rem_sh [AXES];
   logic                  q_bit  [AXES];
   logic [DIV_W-1:0]      rem_in [AXES];

   // Clamp the window length to the supported range
   always_comb begin
      if (int'(window_len_ff) < LEN_MIN) begin
         len_eff = LEN_EFF_W'(LEN_MIN);
      end else if (int'(window_len_ff) > WINDOW_MAX) begin
         len_eff = LEN_EFF_W'(WINDOW_MAX);
      end else begin
         len_eff = LEN_EFF_W'(window_len_ff);
      end
   end

   // Ring slot for the incoming item and the fill state after it
   assign slot_use  = (LEN_EFF_W'(slot_ff) >= len_eff) ? '0 : slot_ff;
   assign slot_next = LEN_EFF_W'(slot_use) + LEN_EFF_W'(1);
   assign wrap      = (slot_next >= len_eff);
   assign divisor   = DIV_W'(len_eff - LEN_EFF_W'(2));
   assign row       = {sample_z, sample_y, sample_x};

   assign status.filled_next = filled_ff || wrap;
   assign status.rd_last     = (LEN_EFF_W'(rd_idx_ff) == (len_eff - LEN_EFF_W'(1)));
   assign status.div_last    = (div_cnt_ff == DCNT_W'(DVD_W - 1));

   // Length register and ring position; a length write restarts the fill
   always_ff @(posedge clock) begin
      if (reset) begin
         window_len_ff <= LEN_W'(LEN_RESET);
         filled_ff     <= 1'b0;
         slot_ff       <= '0;
      end else if (csr_write_en) begin
         window_len_ff <= csr_write_data;
         filled_ff     <= 1'b0;
         slot_ff       <= '0;
      end else if (cmd.write) begin
         if (wrap) begin
            slot_ff   <= '0;
            filled_ff <= 1'b1;
         end else begin
            slot_ff <= slot_next[IDX_W-1:0];
         end
      end
   end

   // Window memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.write) begin
         store_ff[slot_use] <= row;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= store_ff[rd_idx_ff];
      end
   end

   // Walk the read address over the window
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_idx_ff   <= '0;
         rd_vld_ff   <= 1'b0;
         rd_first_ff <= 1'b0;
      end else begin
         rd_vld_ff   <= cmd.rd_en;
         rd_first_ff <= cmd.rd_en && (rd_idx_ff == '0);
         if (cmd.rd_start) begin
            rd_idx_ff <= '0;
         end else if (cmd.rd_en) begin
            rd_idx_ff <= rd_idx_ff + IDX_W'(1);
         end
      end
   end

   // Per-axis trim and one quotient bit per step
   always_comb begin
      for (int l = 0; l < AXES; l++) begin
         trim[l]   = (SUM_W + 1)'(sum_ff[l]) - (SUM_W + 1)'(lo_ff[l])
                   - (SUM_W + 1)'(hi_ff[l]);
         trim_a[l] = trim[l][SUM_W] ? (SUM_W + 1)'(-trim[l]) : trim[l];
         rem_sh[l] = {rem_ff[l], dvd_ff[l][DVD_W-1]};
         q_bit[l]  = (rem_sh[l] >= {1'b0, divisor});
         rem_in[l] = q_bit[l] ? DIV_W'(rem_sh[l] - {1'b0, divisor}) : DIV_W'(rem_sh[l]);
      end
   end

   // Accumulate sum, minimum and maximum; then divide and load the result
   always_ff @(posedge clock) begin
      for (int l = 0; l < AXES; l++) begin
         if (rd_vld_ff) begin
            if (rd_first_ff) begin
               sum_ff[l] <= SUM_W'($signed(rd_data_ff[l*SAMPLE_W +: SAMPLE_W]));
               lo_ff[l]  <= $signed(rd_data_ff[l*SAMPLE_W +: SAMPLE_W]);
               hi_ff[l]  <= $signed(rd_data_ff[l*SAMPLE_W +: SAMPLE_W]);
            end else begin
               sum_ff[l] <= sum_ff[l]
                          + SUM_W'($signed(rd_data_ff[l*SAMPLE_W +: SAMPLE_W]));
               if ($signed(rd_data_ff[l*SAMPLE_W +: SAMPLE_W]) < lo_ff[l]) begin
                  lo_ff[l] <= $signed(rd_data_ff[l*SAMPLE_W +: SAMPLE_W]);
               end
               if ($signed(rd_data_ff[l*SAMPLE_W +: SAMPLE_W]) > hi_ff[l]) begin
                  hi_ff[l] <= $signed(rd_data_ff[l*SAMPLE_W +: SAMPLE_W]);
               end
            end
         end
         if (cmd.div_load) begin
            neg_ff[l] <= trim[l][SUM_W];
            dvd_ff[l] <= {trim_a[l][MAG_W-1:0], FRAC_W'(0)};
            rem_ff[l] <= '0;
         end else if (cmd.div_step) begin
            dvd_ff[l] <= {dvd_ff[l][DVD_W-2:0], q_bit[l]};
            rem_ff[l] <= rem_in[l];
         end
         if (cmd.out_load) begin
            mean_ff[l] <= neg_ff[l] ? MEAN_W'(DVD_W'(0) - dvd_ff[l])
                                    : MEAN_W'(dvd_ff[l]);
         end
      end
   end

   // Count division steps
   always_ff @(posedge clock) begin
      if (reset) begin
         div_cnt_ff <= '0;
      end else if (cmd.div_load) begin
         div_cnt_ff <= '0;
      end else if (cmd.div_step) begin
         div_cnt_ff <= div_cnt_ff + DCNT_W'(1);
      end
   end

   assign mean_x = mean_ff[0];
   assign mean_y = mean_ff[1];
   assign mean_z = mean_ff[2];

endmodule

// ===== src/trimmed_mean_window_filter_xyz.sv =====
// Sequence: with L the window length clamped to 3..16, an item that completes the window
//    is followed by a scan of its L entries, drain, trim, a 27-step shift-subtract divide
//    and the output load that raises rsp_valid; req_stall is high until the controller is idle.
// Filling: items that only fill the window are written in the idle state and give no result.
// A waiting result holds the controller at its output load until taken.
// Reset: synchronous, active high; window length returns to 12, the window is empty.
module trimmed_mean_window_filter_xyz
   import tmwf_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_en,
   input  logic [LEN_W-1:0]           csr_write_data,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic signed [SAMPLE_W-1:0] req_sample_x,
   input  logic signed [SAMPLE_W-1:0] req_sample_y,
   input  logic signed [SAMPLE_W-1:0] req_sample_z,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [MEAN_W-1:0]   rsp_mean_x,
   output logic signed [MEAN_W-1:0]   rsp_mean_y,
   output logic signed [MEAN_W-1:0]   rsp_mean_z
);

   cmd_type    cmd;
   status_type status;

   // Sequencer
   tmwf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Window store, accumulators and divider
   tmwf_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .sample_x       (req_sample_x),
      .sample_y       (req_sample_y),
      .sample_z       (req_sample_z),
      .cmd            (cmd),
      .status         (status),
      .mean_x         (rsp_mean_x),
      .mean_y         (rsp_mean_y),
      .mean_z         (rsp_mean_z)
   );

endmodule

// ===== src/tmwf_check.sv =====
module tmwf_check
   import tmwf_pkg::*;
(
   input logic                       clock,
   input logic                       reset,
   input logic                       csr_write_en,
   input logic [LEN_W-1:0]           csr_write_data,
   input logic                       req_valid,
   input logic                       req_stall,
   input logic signed [SAMPLE_W-1:0] req_sample_x,
   input logic signed [SAMPLE_W-1:0] req_sample_y,
   input logic signed [SAMPLE_W-1:0] req_sample_z,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input logic signed [MEAN_W-1:0]   rsp_mean_x,
   input logic signed [MEAN_W-1:0]   rsp_mean_y,
   input logic signed [MEAN_W-1:0]   rsp_mean_z
);

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_mean_x)
         && $stable(rsp_mean_y) && $stable(rsp_mean_z)))
      else $error("stalled result changed");

   // Reset drops the output valid
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A new result only comes out of a busy cycle
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared without work in progress");

   // The window scan keeps a result from following an item at once
   a_rsp_gap: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> !$rose(rsp_valid))
      else $error("result right after an accepted item");

endmodule

bind trimmed_mean_window_filter_xyz tmwf_check u_tmwf_check (.*);
